// ===== rtl/core/wfe_pkg.sv =====
// Shared constants, types and helper functions of the windowed frequency estimator.
package wfe_pkg;

   localparam int WINDOW_TERMS = 20;
   localparam int SAMPLE_BITS = 16;
   localparam int HIST_DEPTH = WINDOW_TERMS + 4;
   localparam int WIN_DEPTH = HIST_DEPTH + 1;
   localparam int PROD_BITS = 2 * SAMPLE_BITS;
   localparam int SUM_BITS = PROD_BITS + 2 + $clog2(WINDOW_TERMS);
   localparam int DEN_BITS = SUM_BITS + 1;
   localparam int REM_BITS = SUM_BITS + 2;
   localparam int MAC_CNT_BITS = $clog2(WINDOW_TERMS + 1);

   localparam int RATE_BITS = 20;
   localparam int FREQ_BITS = 35;
   localparam int ANGLE_BITS = 18;
   localparam int RATIO_BITS = 17;
   localparam int DIV_STEPS = 17;
   localparam int DIV_CNT_BITS = 5;
   localparam int COS_TERMS = 14;
   localparam int TERM_CNT_BITS = 4;
   localparam int DIVISOR_BITS = 10;

   localparam logic [RATE_BITS-1:0] RATE_RESET = 20'd1000;
   localparam logic [RATIO_BITS-1:0] ONE_Q16 = 17'd65536;
   localparam logic [ANGLE_BITS-1:0] ANGLE_MAX = 18'd205887;
   localparam logic [63:0] ONE_Q62 = 64'h4000_0000_0000_0000;
   localparam logic [63:0] PI_Q62 = 64'hC90F_DAA2_2168_C235;
   localparam logic [63:0] PIHALF_Q62 = 64'h6487_ED51_10B4_611A;
   localparam logic [63:0] FREQ_K = 64'h517C_C1B7_2722_0A95;

   // Reciprocals floor(2^64 / ((2k-1)*2k)) of the cosine series divisors.
   localparam logic [64:0] TWO_POW_64 = 65'h1_0000_0000_0000_0000;
   localparam logic [63:0] RECIP_1 = 64'(TWO_POW_64 / 65'd2);
   localparam logic [63:0] RECIP_2 = 64'(TWO_POW_64 / 65'd12);
   localparam logic [63:0] RECIP_3 = 64'(TWO_POW_64 / 65'd30);
   localparam logic [63:0] RECIP_4 = 64'(TWO_POW_64 / 65'd56);
   localparam logic [63:0] RECIP_5 = 64'(TWO_POW_64 / 65'd90);
   localparam logic [63:0] RECIP_6 = 64'(TWO_POW_64 / 65'd132);
   localparam logic [63:0] RECIP_7 = 64'(TWO_POW_64 / 65'd182);
   localparam logic [63:0] RECIP_8 = 64'(TWO_POW_64 / 65'd240);
   localparam logic [63:0] RECIP_9 = 64'(TWO_POW_64 / 65'd306);
   localparam logic [63:0] RECIP_10 = 64'(TWO_POW_64 / 65'd380);
   localparam logic [63:0] RECIP_11 = 64'(TWO_POW_64 / 65'd462);
   localparam logic [63:0] RECIP_12 = 64'(TWO_POW_64 / 65'd552);
   localparam logic [63:0] RECIP_13 = 64'(TWO_POW_64 / 65'd650);
   localparam logic [63:0] RECIP_14 = 64'(TWO_POW_64 / 65'd756);

   typedef enum logic [4:0] {
      OP_NONE,
      OP_LOAD,
      OP_MAC,
      OP_DIV_INIT,
      OP_DIV_STEP,
      OP_RATIO,
      OP_MID,
      OP_X2_START,
      OP_X2_TAKE,
      OP_TERM_START,
      OP_TERM_TAKE,
      OP_RECIP_START,
      OP_RECIP_TAKE,
      OP_CORR,
      OP_ACCUM,
      OP_SEARCH_UPD,
      OP_RATE_MUL,
      OP_FREQ_START,
      OP_FREQ_TAKE
   } op_type;

   typedef struct packed {
      op_type op;
      logic [TERM_CNT_BITS-1:0] term_k;
      logic req_ready;
      logic rsp_load;
   } dp_cmd_type;

   typedef struct packed {
      logic mul_done;
      logic a_zero;
      logic search_done;
   } dp_stat_type;

   // Divisor (2k-1)*2k of series term k.
   function automatic logic [DIVISOR_BITS-1:0] cos_divisor(input logic [TERM_CNT_BITS-1:0] k);
      case (k)
         4'd1: cos_divisor = 10'd2;
         4'd2: cos_divisor = 10'd12;
         4'd3: cos_divisor = 10'd30;
         4'd4: cos_divisor = 10'd56;
         4'd5: cos_divisor = 10'd90;
         4'd6: cos_divisor = 10'd132;
         4'd7: cos_divisor = 10'd182;
         4'd8: cos_divisor = 10'd240;
         4'd9: cos_divisor = 10'd306;
         4'd10: cos_divisor = 10'd380;
         4'd11: cos_divisor = 10'd462;
         4'd12: cos_divisor = 10'd552;
         4'd13: cos_divisor = 10'd650;
         4'd14: cos_divisor = 10'd756;
         default: cos_divisor = 10'd2;
      endcase
   endfunction

   function automatic logic [63:0] cos_recip(input logic [TERM_CNT_BITS-1:0] k);
      case (k)
         4'd1: cos_recip = RECIP_1;
         4'd2: cos_recip = RECIP_2;
         4'd3: cos_recip = RECIP_3;
         4'd4: cos_recip = RECIP_4;
         4'd5: cos_recip = RECIP_5;
         4'd6: cos_recip = RECIP_6;
         4'd7: cos_recip = RECIP_7;
         4'd8: cos_recip = RECIP_8;
         4'd9: cos_recip = RECIP_9;
         4'd10: cos_recip = RECIP_10;
         4'd11: cos_recip = RECIP_11;
         4'd12: cos_recip = RECIP_12;
         4'd13: cos_recip = RECIP_13;
         4'd14: cos_recip = RECIP_14;
         default: cos_recip = RECIP_1;
      endcase
   endfunction

endpackage

// ===== rtl/core/wfe_if.sv =====
// Channel interfaces for requests, results and the sample rate register.
interface wfe_req_if;
   logic valid;
   logic ready;
   logic signed [wfe_pkg::SAMPLE_BITS-1:0] adc_sample;
   modport source (output valid, output adc_sample, input ready);
   modport sink (input valid, input adc_sample, output ready);
endinterface

interface wfe_rsp_if;
   logic valid;
   logic ready;
   logic [wfe_pkg::FREQ_BITS-1:0] freq_q16;
   logic invalid;
   modport source (output valid, output freq_q16, output invalid, input ready);
   modport sink (input valid, input freq_q16, input invalid, output ready);
endinterface

interface wfe_csr_if;
   logic valid;
   logic ready;
   logic [wfe_pkg::RATE_BITS-1:0] sample_rate_hz;
   modport source (output valid, output sample_rate_hz, input ready);
   modport sink (input valid, input sample_rate_hz, output ready);
endinterface

// ===== rtl/core/wfe_mul.sv =====
// Sequential 64x64 unsigned multiplier built from four 32x32 partial products.
module wfe_mul (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [63:0]  op_a,
   input  logic [63:0]  op_b,
   output logic         done,
   output logic [127:0] prod
);

   logic [63:0]  a_ff;
   logic [63:0]  b_ff;
   logic [2:0]   cnt_ff;
   logic         busy_ff;
   logic         pv_ff;
   logic         done_ff;
   logic [63:0]  pp_ff;
   logic [1:0]   pp_sh_ff;
   logic [127:0] acc_ff;
   logic [31:0]  a_half;
   logic [31:0]  b_half;

   assign a_half = cnt_ff[0] ? a_ff[63:32] : a_ff[31:0];
   assign b_half = cnt_ff[1] ? b_ff[63:32] : b_ff[31:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         pv_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= 3'd0;
      end else begin
         done_ff <= busy_ff && (cnt_ff == 3'd4);
         pv_ff <= busy_ff && (cnt_ff <= 3'd3);
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff <= 3'd0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 3'd1;
            if (cnt_ff == 3'd4) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      pp_ff <= 64'(a_half) * 64'(b_half);
      pp_sh_ff <= 2'(cnt_ff[0]) + 2'(cnt_ff[1]);
      if (start) begin
         a_ff <= op_a;
         b_ff <= op_b;
         acc_ff <= '0;
      end else if (pv_ff) begin
         acc_ff <= acc_ff + (128'(pp_ff) << {pp_sh_ff, 5'b0});
      end
   end

   assign done = done_ff;
   assign prod = acc_ff;

endmodule

// ===== rtl/core/wfe_dp.sv =====
// Datapath: history line, window sums, ratio divider, cosine search and frequency scaling.
module wfe_dp (
   input  logic                                   clock,
   input  logic                                   reset,
   input  wfe_pkg::dp_cmd_type                    cmd,
   input  logic signed [wfe_pkg::SAMPLE_BITS-1:0] sample,
   input  logic [wfe_pkg::RATE_BITS-1:0]          rate,
   output wfe_pkg::dp_stat_type                   stat,
   output logic [wfe_pkg::FREQ_BITS-1:0]          res_freq,
   output logic                                   res_invalid
);

   logic signed [wfe_pkg::SAMPLE_BITS-1:0] hist_ff [wfe_pkg::HIST_DEPTH];
   logic signed [wfe_pkg::SAMPLE_BITS-1:0] win_ff [wfe_pkg::WIN_DEPTH];
   logic signed [wfe_pkg::PROD_BITS-1:0]   pa0_ff, pa1_ff, pb0_ff, pb1_ff;
   logic                                   pv_ff;
   logic signed [wfe_pkg::SUM_BITS-1:0]    a_ff, b_ff;

   logic [wfe_pkg::DEN_BITS-1:0]   den_ff;
   logic [wfe_pkg::REM_BITS-1:0]   rem_ff;
   logic [wfe_pkg::RATIO_BITS-1:0] q_ff;
   logic                           big_ff;
   logic                           neg_ff;
   logic [63:0]                    rq_ff;

   logic [wfe_pkg::ANGLE_BITS-1:0] lo_ff, hi_ff, mid_ff;
   logic                           reflect_ff;
   logic [63:0]                    x2_ff, term_ff, sum_ff, p_ff, q0_ff, qc_ff;
   logic [wfe_pkg::RATE_BITS+wfe_pkg::ANGLE_BITS-1:0] ra_ff;
   logic [wfe_pkg::FREQ_BITS-1:0]  res_freq_ff;
   logic                           res_invalid_ff;

   logic [wfe_pkg::SUM_BITS-1:0]   a_abs, b_abs;
   logic [wfe_pkg::REM_BITS-1:0]   den_ext;
   logic                           div_ge;
   logic [wfe_pkg::REM_BITS-1:0]   div_diff;
   logic                           ratio_bad;
   logic [wfe_pkg::RATIO_BITS-1:0] q_sat;
   logic [wfe_pkg::ANGLE_BITS-1:0] r_signed;
   logic [63:0]                    h_val;
   logic                           h_reflect;
   logic [63:0]                    x_val;
   logic [63:0]                    corr_rem;
   logic [63:0]                    divisor_ext;
   logic [63:0]                    cos_val;
   logic                           mul_start;
   logic [63:0]                    mul_a, mul_b;
   logic                           mul_done;
   logic [127:0]                   mul_prod;

   assign a_abs = a_ff[wfe_pkg::SUM_BITS-1] ? wfe_pkg::SUM_BITS'(-a_ff) : a_ff;
   assign b_abs = b_ff[wfe_pkg::SUM_BITS-1] ? wfe_pkg::SUM_BITS'(-b_ff) : b_ff;
   assign den_ext = wfe_pkg::REM_BITS'(den_ff);
   assign div_ge = rem_ff >= den_ext;
   assign div_diff = div_ge ? (rem_ff - den_ext) : rem_ff;

   assign ratio_bad = big_ff || (q_ff > wfe_pkg::ONE_Q16);
   assign q_sat = ratio_bad ? wfe_pkg::ONE_Q16 : q_ff;
   assign r_signed = neg_ff ? -wfe_pkg::ANGLE_BITS'(q_sat) : wfe_pkg::ANGLE_BITS'(q_sat);

   // Half-step sample point (2*mid+1)/2^17 in Q.62, folded into [0, pi/2].
   assign h_val = 64'({mid_ff, 1'b1}) << 45;
   assign h_reflect = h_val > wfe_pkg::PIHALF_Q62;
   assign x_val = h_reflect ? (wfe_pkg::PI_Q62 - h_val) : h_val;

   assign divisor_ext = 64'(wfe_pkg::cos_divisor(cmd.term_k));
   assign corr_rem = p_ff - qc_ff;
   assign cos_val = reflect_ff ? -sum_ff : sum_ff;

   always_comb begin
      mul_start = 1'b0;
      mul_a = term_ff;
      mul_b = x2_ff;
      case (cmd.op)
         wfe_pkg::OP_X2_START: begin
            mul_start = 1'b1;
            mul_a = x_val;
            mul_b = x_val;
         end
         wfe_pkg::OP_TERM_START: begin
            mul_start = 1'b1;
         end
         wfe_pkg::OP_RECIP_START: begin
            mul_start = 1'b1;
            mul_a = p_ff;
            mul_b = wfe_pkg::cos_recip(cmd.term_k);
         end
         wfe_pkg::OP_FREQ_START: begin
            mul_start = 1'b1;
            mul_a = 64'(ra_ff);
            mul_b = wfe_pkg::FREQ_K;
         end
         default: begin
            mul_start = 1'b0;
         end
      endcase
   end

   wfe_mul u_mul (
      .clock (clock),
      .reset (reset),
      .start (mul_start),
      .op_a  (mul_a),
      .op_b  (mul_b),
      .done  (mul_done),
      .prod  (mul_prod)
   );

   // The history line has a defined reset value of all zeros.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < wfe_pkg::HIST_DEPTH; i++) begin
            hist_ff[i] <= '0;
         end
         pv_ff <= 1'b0;
      end else begin
         pv_ff <= (cmd.op == wfe_pkg::OP_MAC);
         if (cmd.op == wfe_pkg::OP_LOAD) begin
            hist_ff[0] <= sample;
            for (int i = 1; i < wfe_pkg::HIST_DEPTH; i++) begin
               hist_ff[i] <= hist_ff[i-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      pa0_ff <= win_ff[0] * win_ff[3];
      pa1_ff <= win_ff[1] * win_ff[2];
      pb0_ff <= win_ff[0] * win_ff[5];
      pb1_ff <= win_ff[1] * win_ff[4];
      if (cmd.op == wfe_pkg::OP_LOAD) begin
         a_ff <= '0;
         b_ff <= '0;
      end else if (pv_ff) begin
         a_ff <= a_ff + wfe_pkg::SUM_BITS'(pa0_ff) - wfe_pkg::SUM_BITS'(pa1_ff);
         b_ff <= b_ff + wfe_pkg::SUM_BITS'(pb0_ff) - wfe_pkg::SUM_BITS'(pb1_ff);
      end

      case (cmd.op)
         wfe_pkg::OP_LOAD: begin
            win_ff[0] <= sample;
            for (int i = 0; i < wfe_pkg::HIST_DEPTH; i++) begin
               win_ff[i+1] <= hist_ff[i];
            end
         end
         wfe_pkg::OP_MAC: begin
            for (int i = 0; i < wfe_pkg::WIN_DEPTH - 1; i++) begin
               win_ff[i] <= win_ff[i+1];
            end
         end
         wfe_pkg::OP_DIV_INIT: begin
            den_ff <= {a_abs, 1'b0};
            rem_ff <= wfe_pkg::REM_BITS'(b_abs);
            big_ff <= wfe_pkg::REM_BITS'(b_abs) >= wfe_pkg::REM_BITS'({a_abs, 2'b00});
            neg_ff <= a_ff[wfe_pkg::SUM_BITS-1] ^ b_ff[wfe_pkg::SUM_BITS-1];
            q_ff <= '0;
            res_freq_ff <= '0;
            res_invalid_ff <= 1'b1;
         end
         wfe_pkg::OP_DIV_STEP: begin
            q_ff <= {q_ff[wfe_pkg::RATIO_BITS-2:0], div_ge};
            rem_ff <= div_diff << 1;
         end
         wfe_pkg::OP_RATIO: begin
            res_invalid_ff <= ratio_bad;
            rq_ff <= {r_signed, 46'd0};
            lo_ff <= '0;
            hi_ff <= wfe_pkg::ANGLE_MAX;
         end
         wfe_pkg::OP_MID: begin
            mid_ff <= wfe_pkg::ANGLE_BITS'((19'(lo_ff) + 19'(hi_ff)) >> 1);
         end
         wfe_pkg::OP_X2_START: begin
            reflect_ff <= h_reflect;
         end
         wfe_pkg::OP_X2_TAKE: begin
            x2_ff <= mul_prod[125:62];
            term_ff <= wfe_pkg::ONE_Q62;
            sum_ff <= wfe_pkg::ONE_Q62;
         end
         wfe_pkg::OP_TERM_TAKE: begin
            p_ff <= mul_prod[125:62];
         end
         wfe_pkg::OP_RECIP_TAKE: begin
            q0_ff <= mul_prod[127:64];
            qc_ff <= mul_prod[127:64] * divisor_ext;
         end
         wfe_pkg::OP_CORR: begin
            // The reciprocal estimate is low by at most one.
            term_ff <= (corr_rem >= divisor_ext) ? (q0_ff + 64'd1) : q0_ff;
         end
         wfe_pkg::OP_ACCUM: begin
            sum_ff <= cmd.term_k[0] ? (sum_ff - term_ff) : (sum_ff + term_ff);
         end
         wfe_pkg::OP_SEARCH_UPD: begin
            if ($signed(cos_val) <= $signed(rq_ff)) begin
               hi_ff <= mid_ff;
            end else begin
               lo_ff <= mid_ff + wfe_pkg::ANGLE_BITS'(1);
            end
         end
         wfe_pkg::OP_RATE_MUL: begin
            ra_ff <= (wfe_pkg::RATE_BITS + wfe_pkg::ANGLE_BITS)'(rate) *
                     (wfe_pkg::RATE_BITS + wfe_pkg::ANGLE_BITS)'(lo_ff);
         end
         wfe_pkg::OP_FREQ_TAKE: begin
            res_freq_ff <= mul_prod[100:66];
         end
         default: begin
         end
      endcase
   end

   assign stat.mul_done = mul_done;
   assign stat.a_zero = (a_ff == '0);
   assign stat.search_done = !(lo_ff < hi_ff);
   assign res_freq = res_freq_ff;
   assign res_invalid = res_invalid_ff;

endmodule

// ===== rtl/core/wfe_ctrl.sv =====
// Controller: sequences window sums, division, the cosine search and the frequency product.
module wfe_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 rsp_free,
   input  wfe_pkg::dp_stat_type stat,
   output wfe_pkg::dp_cmd_type  cmd
);

   typedef enum logic [20:0] {
      S_IDLE       = 21'h000001,
      S_MAC        = 21'h000002,
      S_MAC_END    = 21'h000004,
      S_DIV_INIT   = 21'h000008,
      S_DIV        = 21'h000010,
      S_RATIO      = 21'h000020,
      S_CHECK      = 21'h000040,
      S_MID        = 21'h000080,
      S_X2         = 21'h000100,
      S_X2_WAIT    = 21'h000200,
      S_TERM       = 21'h000400,
      S_TERM_WAIT  = 21'h000800,
      S_RECIP      = 21'h001000,
      S_RECIP_WAIT = 21'h002000,
      S_CORR       = 21'h004000,
      S_ACCUM      = 21'h008000,
      S_UPDATE     = 21'h010000,
      S_RATE       = 21'h020000,
      S_FREQ       = 21'h040000,
      S_FREQ_WAIT  = 21'h080000,
      S_OUT        = 21'h100000
   } state_type;

   state_type                             state_ff, state_in;
   logic [wfe_pkg::MAC_CNT_BITS-1:0]      mac_cnt_ff, mac_cnt_in;
   logic [wfe_pkg::DIV_CNT_BITS-1:0]      div_cnt_ff, div_cnt_in;
   logic [wfe_pkg::TERM_CNT_BITS-1:0]     term_k_ff, term_k_in;

   always_comb begin
      state_in = state_ff;
      mac_cnt_in = mac_cnt_ff;
      div_cnt_in = div_cnt_ff;
      term_k_in = term_k_ff;
      cmd.op = wfe_pkg::OP_NONE;
      cmd.term_k = term_k_ff;
      cmd.req_ready = 1'b0;
      cmd.rsp_load = 1'b0;
      case (state_ff)
         S_IDLE: begin
            cmd.req_ready = 1'b1;
            if (req_valid) begin
               cmd.op = wfe_pkg::OP_LOAD;
               mac_cnt_in = '0;
               state_in = S_MAC;
            end
         end
         S_MAC: begin
            cmd.op = wfe_pkg::OP_MAC;
            if (mac_cnt_ff == wfe_pkg::MAC_CNT_BITS'(wfe_pkg::WINDOW_TERMS - 1)) begin
               state_in = S_MAC_END;
            end else begin
               mac_cnt_in = mac_cnt_ff + 1'b1;
            end
         end
         S_MAC_END: begin
            state_in = S_DIV_INIT;
         end
         S_DIV_INIT: begin
            cmd.op = wfe_pkg::OP_DIV_INIT;
            div_cnt_in = '0;
            state_in = stat.a_zero ? S_OUT : S_DIV;
         end
         S_DIV: begin
            cmd.op = wfe_pkg::OP_DIV_STEP;
            if (div_cnt_ff == wfe_pkg::DIV_CNT_BITS'(wfe_pkg::DIV_STEPS - 1)) begin
               state_in = S_RATIO;
            end else begin
               div_cnt_in = div_cnt_ff + 1'b1;
            end
         end
         S_RATIO: begin
            cmd.op = wfe_pkg::OP_RATIO;
            state_in = S_CHECK;
         end
         S_CHECK: begin
            state_in = stat.search_done ? S_RATE : S_MID;
         end
         S_MID: begin
            cmd.op = wfe_pkg::OP_MID;
            state_in = S_X2;
         end
         S_X2: begin
            cmd.op = wfe_pkg::OP_X2_START;
            state_in = S_X2_WAIT;
         end
         S_X2_WAIT: begin
            if (stat.mul_done) begin
               cmd.op = wfe_pkg::OP_X2_TAKE;
               term_k_in = wfe_pkg::TERM_CNT_BITS'(1);
               state_in = S_TERM;
            end
         end
         S_TERM: begin
            cmd.op = wfe_pkg::OP_TERM_START;
            state_in = S_TERM_WAIT;
         end
         S_TERM_WAIT: begin
            if (stat.mul_done) begin
               cmd.op = wfe_pkg::OP_TERM_TAKE;
               state_in = S_RECIP;
            end
         end
         S_RECIP: begin
            cmd.op = wfe_pkg::OP_RECIP_START;
            state_in = S_RECIP_WAIT;
         end
         S_RECIP_WAIT: begin
            if (stat.mul_done) begin
               cmd.op = wfe_pkg::OP_RECIP_TAKE;
               state_in = S_CORR;
            end
         end
         S_CORR: begin
            cmd.op = wfe_pkg::OP_CORR;
            state_in = S_ACCUM;
         end
         S_ACCUM: begin
            cmd.op = wfe_pkg::OP_ACCUM;
            if (term_k_ff == wfe_pkg::TERM_CNT_BITS'(wfe_pkg::COS_TERMS)) begin
               state_in = S_UPDATE;
            end else begin
               term_k_in = term_k_ff + 1'b1;
               state_in = S_TERM;
            end
         end
         S_UPDATE: begin
            cmd.op = wfe_pkg::OP_SEARCH_UPD;
            state_in = S_CHECK;
         end
         S_RATE: begin
            cmd.op = wfe_pkg::OP_RATE_MUL;
            state_in = S_FREQ;
         end
         S_FREQ: begin
            cmd.op = wfe_pkg::OP_FREQ_START;
            state_in = S_FREQ_WAIT;
         end
         S_FREQ_WAIT: begin
            if (stat.mul_done) begin
               cmd.op = wfe_pkg::OP_FREQ_TAKE;
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         mac_cnt_ff <= '0;
         div_cnt_ff <= '0;
         term_k_ff <= '0;
      end else begin
         state_ff <= state_in;
         mac_cnt_ff <= mac_cnt_in;
         div_cnt_ff <= div_cnt_in;
         term_k_ff <= term_k_in;
      end
   end

endmodule

// ===== rtl/core/windowed_frequency_estimator.sv =====
// Top level of the windowed frequency estimator: channels, rate register and result register.
//
//   channel  direction  handshake              payload
//   req_ch   in         valid / ready          adc_sample (16-bit signed)
//   rsp_ch   out        valid / ready          freq_q16 (35-bit, Q.16 Hz), invalid
//   csr_ch   in         valid / ready (=1)     sample_rate_hz (20-bit)
//
// One request is worked on at a time. The window sums are formed first, then the ratio divider
// runs. The arc cosine is a binary search of 17 or 18 steps, and each step evaluates a
// 14-term cosine series on the one shared 64x64 multiplier (four 32x32 partial products).
// When the window sum A is zero, the division and the search are skipped.
// Reset is synchronous and clears the controller, the rate register (to 1000 Hz), the history
// line and the result valid flag. A finished result waits in the output register while the next
// request is accepted; the controller stalls only when a newer result is ready before the older
// one has been taken.
module windowed_frequency_estimator (
   input logic clock,
   input logic reset,
   wfe_req_if.sink   req_ch,
   wfe_rsp_if.source rsp_ch,
   wfe_csr_if.sink   csr_ch
);

   wfe_pkg::dp_cmd_type  cmd;
   wfe_pkg::dp_stat_type stat;

   logic [wfe_pkg::RATE_BITS-1:0] rate_ff;
   logic                          rsp_valid_ff;
   logic [wfe_pkg::FREQ_BITS-1:0] rsp_freq_ff;
   logic                          rsp_invalid_ff;
   logic [wfe_pkg::FREQ_BITS-1:0] res_freq;
   logic                          res_invalid;
   logic                          rsp_free;

   // The output register can take a new result when it is empty or being drained.
   assign rsp_free = !rsp_valid_ff || rsp_ch.ready;

   wfe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .rsp_free  (rsp_free),
      .stat      (stat),
      .cmd       (cmd)
   );

   wfe_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sample      (req_ch.adc_sample),
      .rate        (rate_ff),
      .stat        (stat),
      .res_freq    (res_freq),
      .res_invalid (res_invalid)
   );

   // Always ready; the user writes the rate register only while the block is idle (unchecked).
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff <= wfe_pkg::RATE_RESET;
      end else if (csr_ch.valid) begin
         rate_ff <= csr_ch.sample_rate_hz;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_freq_ff <= res_freq;
         rsp_invalid_ff <= res_invalid;
      end
   end

   assign req_ch.ready = cmd.req_ready;
   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.freq_q16 = rsp_freq_ff;
   assign rsp_ch.invalid = rsp_invalid_ff;

endmodule

// ===== tb/sv/windowed_frequency_estimator_checker.sv =====
// Checker of the windowed frequency estimator: predicts every result and compares it.
module windowed_frequency_estimator_checker (
   input  logic clock,
   input  logic reset,
   wfe_req_if   req_ch,
   wfe_rsp_if   rsp_ch,
   wfe_csr_if   csr_ch,
   output int   fail_count,
   output int   pending_count,
   output int   result_count,
   output int   flagged_count
);

   typedef struct packed {
      logic [wfe_pkg::FREQ_BITS-1:0] freq_q16;
      logic invalid;
   } freq_result_type;

   logic [wfe_pkg::RATE_BITS-1:0] rate_hz;
   longint sample_line [wfe_pkg::HIST_DEPTH];
   freq_result_type freq_queue [$];

   function automatic logic [63:0] fix_mul(input logic [63:0] a, input logic [63:0] b);
      logic [127:0] p;
      p = {64'd0, a} * {64'd0, b};
      return p[125:62];
   endfunction

   // Cosine of an angle in [0, pi/2], both in Q.62, by the truncated Taylor series.
   function automatic longint cosine_q62(input logic [63:0] x);
      logic [63:0] x2, term;
      longint sum;
      x2 = fix_mul(x, x);
      term = wfe_pkg::ONE_Q62;
      sum = longint'(term);
      for (int k = 1; k <= wfe_pkg::COS_TERMS; k++) begin
         term = fix_mul(term, x2) / 64'((2 * k - 1) * (2 * k));
         if (k % 2 == 1) sum -= longint'(term);
         else sum += longint'(term);
      end
      return sum;
   endfunction

   function automatic longint cosine_mid(input int unsigned k);
      logic [63:0] h;
      h = 64'(2 * k + 1) << 45;
      if (h <= wfe_pkg::PIHALF_Q62) return cosine_q62(h);
      return -cosine_q62(wfe_pkg::PI_Q62 - h);
   endfunction

   // Arc cosine in Q2.16 as the count of half points whose cosine exceeds the ratio.
   function automatic int unsigned arc_cosine(input int ratio);
      longint rq;
      int unsigned lo, hi, mid;
      rq = longint'(ratio) * (longint'(1) << 46);
      lo = 0;
      hi = wfe_pkg::ANGLE_MAX;
      while (lo < hi) begin
         mid = (lo + hi) / 2;
         if (cosine_mid(mid) <= rq) hi = mid;
         else lo = mid + 1;
      end
      return lo;
   endfunction

   function automatic freq_result_type estimate_freq(
         input logic signed [wfe_pkg::SAMPLE_BITS-1:0] x);
      longint w [wfe_pkg::WIN_DEPTH];
      longint a, b;
      logic [63:0] num, den, ip, rem;
      logic [127:0] p;
      int unsigned q, frac, angle;
      int ratio;
      logic neg, clamped;
      freq_result_type res;
      w[0] = longint'(x);
      for (int i = 0; i < wfe_pkg::HIST_DEPTH; i++) w[i + 1] = sample_line[i];
      a = 0;
      b = 0;
      for (int i = 0; i < wfe_pkg::WINDOW_TERMS; i++) begin
         a += w[i] * w[i + 3] - w[i + 1] * w[i + 2];
         b += w[i] * w[i + 5] - w[i + 1] * w[i + 4];
      end
      for (int i = wfe_pkg::HIST_DEPTH - 1; i > 0; i--) sample_line[i] = sample_line[i - 1];
      sample_line[0] = w[0];
      if (a == 0) begin
         res.freq_q16 = '0;
         res.invalid = 1'b1;
         return res;
      end
      clamped = 1'b0;
      neg = (a < 0) != (b < 0);
      num = (b < 0) ? -b : b;
      den = 2 * ((a < 0) ? -a : a);
      ip = num / den;
      rem = num % den;
      if (ip > 1) begin
         q = wfe_pkg::ONE_Q16;
         clamped = 1'b1;
      end else begin
         frac = 0;
         for (int i = 0; i < 16; i++) begin
            rem = rem << 1;
            frac = frac << 1;
            if (rem >= den) begin
               rem -= den;
               frac |= 1;
            end
         end
         q = ip * wfe_pkg::ONE_Q16 + frac;
         if (q > wfe_pkg::ONE_Q16) begin
            q = wfe_pkg::ONE_Q16;
            clamped = 1'b1;
         end
      end
      ratio = neg ? -int'(q) : int'(q);
      angle = arc_cosine(ratio);
      p = {64'd0, 64'(rate_hz) * 64'(angle)} * {64'd0, wfe_pkg::FREQ_K};
      res.freq_q16 = p[100:66];
      res.invalid = clamped;
      return res;
   endfunction

   always @(posedge clock) begin
      freq_result_type got, want;
      int errs;
      errs = 0;
      if (reset) begin
         rate_hz <= wfe_pkg::RATE_RESET;
         for (int i = 0; i < wfe_pkg::HIST_DEPTH; i++) sample_line[i] = 0;
         freq_queue.delete();
         fail_count <= 0;
         pending_count <= 0;
         result_count <= 0;
         flagged_count <= 0;
      end else begin
         if (csr_ch.valid && csr_ch.ready) rate_hz <= csr_ch.sample_rate_hz;
         if (req_ch.valid && req_ch.ready)
            freq_queue.insert(freq_queue.size(), estimate_freq(req_ch.adc_sample));
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.freq_q16 = rsp_ch.freq_q16;
            got.invalid = rsp_ch.invalid;
            result_count <= result_count + 1;
            if (got.invalid) flagged_count <= flagged_count + 1;
            if (freq_queue.size() == 0) begin
               $error("result with nothing expected: freq_q16 %0d invalid %0d",
                      got.freq_q16, got.invalid);
               errs++;
            end else begin
               want = freq_queue.pop_front();
               if (got.freq_q16 !== want.freq_q16) begin
                  $error("freq_q16 expected %0d actual %0d", want.freq_q16, got.freq_q16);
                  errs++;
               end
               if (got.invalid !== want.invalid) begin
                  $error("invalid expected %0d actual %0d", want.invalid, got.invalid);
                  errs++;
               end
            end
         end
         fail_count <= fail_count + errs;
         pending_count <= freq_queue.size();
      end
   end
endmodule

// ===== tb/sv/windowed_frequency_estimator_tb.sv =====
// Testbench top of the windowed frequency estimator: clock, reset, stimulus and verdict.
module windowed_frequency_estimator_tb;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int fail_count, pending_count, result_count, flagged_count;
   int sent_count = 0;
   // When set, the result sink never pauses and the sample source pauses only at burst ends.
   logic steady = 1'b0;

   wfe_req_if req_ch ();
   wfe_rsp_if rsp_ch ();
   wfe_csr_if csr_ch ();

   windowed_frequency_estimator uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   windowed_frequency_estimator_checker checker_inst (
      .clock         (clock),
      .reset         (reset),
      .req_ch        (req_ch),
      .rsp_ch        (rsp_ch),
      .csr_ch        (csr_ch),
      .fail_count    (fail_count),
      .pending_count (pending_count),
      .result_count  (result_count),
      .flagged_count (flagged_count)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // The result sink drops ready on about a third of the cycles unless a steady stretch runs.
   always @(negedge clock) begin
      rsp_ch.ready <= steady || ($urandom_range(99) >= 34);
   end

   // Each call assigns valid exactly once per falling edge, so a valid that stays high
   // from one request to the next is never dropped and raised within one time step.
   task automatic send_sample(input int value);
      logic signed [wfe_pkg::SAMPLE_BITS-1:0] x;
      if (value > 32767) x = 16'sd32767;
      else if (value < -32768) x = -16'sd32768;
      else x = wfe_pkg::SAMPLE_BITS'(value);
      @(negedge clock);
      while (!steady && $urandom_range(99) < 34) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.adc_sample <= x;
      do @(posedge clock); while (!req_ch.ready);
      sent_count++;
   endtask

   task automatic end_burst();
      @(negedge clock);
      req_ch.valid <= 1'b0;
   endtask

   // The rate register is written only once every outstanding result has been taken.
   task automatic write_rate(input logic [wfe_pkg::RATE_BITS-1:0] rate);
      while (pending_count != 0) @(posedge clock);
      @(negedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.sample_rate_hz <= rate;
      do @(posedge clock); while (!csr_ch.ready);
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   // A noisy sinusoid of random pitch and amplitude; most random stimulus has this shape
   // so that the window sums describe a real tone and the arc cosine sees real ratios.
   task automatic send_tone(input int count);
      real step, phase, amp;
      int noise, value;
      step = 6.283185307 * ($urandom_range(1, 490) / 1000.0);
      phase = $urandom_range(0, 6283) / 1000.0;
      amp = $urandom_range(1, 36000);
      noise = $urandom_range(0, 3) == 0 ? $urandom_range(0, 3000) : $urandom_range(0, 20);
      for (int n = 0; n < count; n++) begin
         value = $rtoi(amp * $sin(phase + step * n));
         if (noise != 0) value += $urandom_range(0, 2 * noise) - noise;
         send_sample(value);
      end
   endtask

   task automatic send_noise(input int count);
      for (int n = 0; n < count; n++) begin
         case ($urandom_range(0, 3))
            0: send_sample(int'($signed(16'($urandom))));
            1: send_sample($urandom_range(0, 1) ? 32767 : -32768);
            2: send_sample(0);
            default: send_sample($urandom_range(0, 64) - 32);
         endcase
      end
   endtask

   task automatic random_phase(input int target);
      int start;
      start = sent_count;
      while (sent_count - start < target) begin
         if ($urandom_range(0, 99) < 80) send_tone($urandom_range(25, 60));
         else send_noise($urandom_range(1, 12));
         if ($urandom_range(0, 3) == 0) end_burst();
      end
      end_burst();
   endtask

   initial begin
      req_ch.valid = 1'b0;
      req_ch.adc_sample = '0;
      csr_ch.valid = 1'b0;
      csr_ch.sample_rate_hz = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part at the reset rate: an all-zero line gives a zero denominator,
      // then the sample extremes, a full-scale alternation and a tone.
      send_sample(0);
      send_sample(32767);
      send_sample(-32768);
      send_sample(32767);
      send_sample(-32768);
      send_sample(1);
      send_sample(-1);
      send_sample(0);
      end_burst();
      send_tone(16);
      end_burst();

      // Rate extremes: the smallest nonzero value and the top of the register.
      write_rate(20'd1);
      send_sample(12000);
      send_sample(-7000);
      end_burst();
      write_rate(20'hFFFFF);
      send_sample(-30000);
      end_burst();

      write_rate(20'd1000000);
      random_phase(150);
      write_rate(20'd0);
      random_phase(30);
      write_rate(20'd1);
      random_phase(100);
      // A stretch in which the sink never idles and the source idles only at burst ends.
      steady = 1'b1;
      write_rate(20'(50 + $urandom_range(0, 20000)));
      random_phase(150);
      steady = 1'b0;
      write_rate(20'hFFFFF);
      random_phase(120);
      write_rate(20'($urandom_range(1, 1000000)));
      random_phase(150);

      while (pending_count != 0) @(posedge clock);
      repeat (5000) @(posedge clock);

      $display("Sent %0d samples over rates 0 to 1048575; %0d results checked, %0d flagged.",
               sent_count, result_count, flagged_count);
      $display("Tones, noise, full-scale extremes and zero lines were covered.");
      if (fail_count == 0 && pending_count == 0)
         $display("windowed_frequency_estimator verification clean");
      else
         $display("windowed_frequency_estimator verification failed");
      $finish;
   end

   // The timeout allows many times the slowest correct run.
   initial begin
      #1000000000;
      $display("windowed_frequency_estimator verification failed");
      $finish;
   end
endmodule
